>>> sv/mfs_pkg.sv
// shared types, constants and function codes for the feedback scheduler
// no dependencies
`timescale 1ns / 1ps
package mfs_pkg;
    localparam int DEF_SLOTS  = 64;
    localparam int DEF_LEVELS = 5;
    localparam int FUNC_W     = 3;
    localparam int SLOT_W     = 6;
    localparam int LVL_W      = 3;
    localparam int REG_W      = 16;
    localparam int RC_W       = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_SLICE  = 5;

    localparam logic [FUNC_W-1:0] F_TICK     = 3'd0;
    localparam logic [FUNC_W-1:0] F_CREATE   = 3'd1;
    localparam logic [FUNC_W-1:0] F_RUNNABLE = 3'd2;
    localparam logic [FUNC_W-1:0] F_SLEEP    = 3'd3;
    localparam logic [FUNC_W-1:0] F_FREE     = 3'd4;
    localparam logic [FUNC_W-1:0] F_MARK     = 3'd5;
    localparam logic [FUNC_W-1:0] F_SCHED    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_AGING = 3'd5;

    localparam logic [1:0] ST_UNUSED   = 2'd0;
    localparam logic [1:0] ST_HELD     = 2'd1;
    localparam logic [1:0] ST_RUNNABLE = 2'd2;
    localparam logic [1:0] ST_RUNNING  = 2'd3;

    localparam logic [REG_W-1:0] DEF_SLICE [NUM_SLICE] = '{16'd1, 16'd2, 16'd4, 16'd8, 16'd16};
    localparam logic [REG_W-1:0] DEF_AGING = 16'd200;

    typedef struct packed {
        logic [1:0]        st;
        logic [LVL_W-1:0]  lv;
        logic [RC_W-1:0]   rc;
        logic [TIME_W-1:0] enq;
        logic [TIME_W-1:0] last;
        logic              mark;
    } t_slot;
endpackage

>>> sv/mfs_slot_mem.sv
// slot table memory, one write and one registered read port
// depends on mfs_pkg
`timescale 1ns / 1ps
module mfs_slot_mem #(
    parameter int SLOTS = mfs_pkg::DEF_SLOTS,
    parameter int IDX_W = $clog2(SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [IDX_W-1:0]   i_waddr,
    input  mfs_pkg::t_slot     i_wdata,
    input  logic [IDX_W-1:0]   i_raddr,
    output mfs_pkg::t_slot     o_rdata
);
    import mfs_pkg::*;

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/multilevel_feedback_scheduler.sv
// multilevel feedback queue scheduler over a memory-held slot table
// depends on mfs_pkg and mfs_slot_mem
//
// channel  direction  signals
// in       input      i_in_valid / o_in_ready, i_func, i_slot
// out      output     o_out_valid / i_out_ready, o_found, o_chosen_slot, o_chosen_level
// cfg      input      i_cfg_we, i_cfg_idx, i_cfg_data
//
// single-slot events go through memory read, modify and write, then result
// tick walks the table once through the memory port
// schedule runs the walk, pick flush and write-back of the pick
// after reset the table is cleared one entry a cycle, with o_in_ready low
// a result waiting in the output register stalls the next result, and new input with it
`timescale 1ns / 1ps
module multilevel_feedback_scheduler #(
    parameter int SLOTS  = mfs_pkg::DEF_SLOTS,
    parameter int LEVELS = mfs_pkg::DEF_LEVELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mfs_pkg::FUNC_W-1:0]      i_func,
    input  logic [mfs_pkg::SLOT_W-1:0]      i_slot,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [mfs_pkg::SLOT_W-1:0]      o_chosen_slot,
    output logic [mfs_pkg::LVL_W-1:0]       o_chosen_level,
    input  logic                            i_cfg_we,
    input  logic [mfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mfs_pkg::REG_W-1:0]       i_cfg_data
);
    import mfs_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [LVL_W-1:0] BOTTOM = LVL_W'(LEVELS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SREAD = 6'b000100,
        S_WALK  = 6'b001000,
        S_LAST  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [REG_W-1:0]     r_slice [NUM_SLICE];
    logic [REG_W-1:0]     r_aging;
    logic [TIME_W-1:0]    r_time;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [FUNC_W-1:0]    r_func;
    logic [IDX_W-1:0]     r_slot;
    logic                 r_ok;
    logic                 r_v1, n_v1;
    logic [IDX_W-1:0]     r_a1;
    logic                 r_v2;
    t_slot                r_e2;
    logic [IDX_W-1:0]     r_a2;
    logic                 r_have;
    t_slot                r_best;
    logic [IDX_W-1:0]     r_best_a;
    logic                 r_pf;
    logic [SLOT_W-1:0]    r_ps;
    logic [LVL_W-1:0]     r_pl;
    logic                 r_out_valid;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_cslot;
    logic [LVL_W-1:0]     r_clvl;

    logic                 accept, is_walk, is_sched;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic                 wr_en;
    t_slot                wr_data, rdata, upd;
    logic [REG_W-1:0]     slice_sel;
    logic                 take;

    mfs_slot_mem #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign accept   = i_in_valid && o_in_ready;
    assign is_walk  = (i_func == F_TICK) || (i_func == F_SCHED);
    assign is_sched = (r_func == F_SCHED);
    assign o_in_ready = (r_state == S_IDLE);

    // per-slot update of the entry read last cycle
    always_comb begin
        upd = rdata;
        slice_sel = (rdata.lv >= LVL_W'(4)) ? r_slice[NUM_SLICE-1] : r_slice[rdata.lv];
        case (r_func)
            F_TICK: begin
                if (rdata.st == ST_RUNNING) begin
                    if (rdata.rc != '1) begin
                        upd.rc = rdata.rc + RC_W'(1);
                    end
                    upd.last = r_time;
                end
            end
            F_SCHED: begin
                if (rdata.st == ST_RUNNABLE) begin
                    if (rdata.rc >= slice_sel && rdata.lv < BOTTOM) begin
                        upd.lv  = rdata.lv + LVL_W'(1);
                        upd.enq = r_time;
                        upd.rc  = '0;
                    end
                    if ((r_time - rdata.last) > TIME_W'(r_aging) && upd.lv != '0) begin
                        upd.lv  = upd.lv - LVL_W'(1);
                        upd.enq = r_time;
                        upd.rc  = '0;
                    end
                    if (rdata.mark && upd.lv < BOTTOM) begin
                        upd.mark = 1'b0;
                        upd.lv   = upd.lv + LVL_W'(1);
                        upd.enq  = r_time;
                        upd.rc   = '0;
                    end
                end
            end
            F_CREATE: begin
                if (rdata.st == ST_UNUSED) begin
                    upd.st   = ST_HELD;
                    upd.lv   = '0;
                    upd.rc   = '0;
                    upd.enq  = r_time;
                    upd.last = r_time;
                    upd.mark = 1'b0;
                end
            end
            F_RUNNABLE: begin
                if (rdata.st == ST_HELD || rdata.st == ST_RUNNING) begin
                    upd.st = ST_RUNNABLE;
                end
            end
            F_SLEEP: begin
                if (rdata.st != ST_UNUSED) begin
                    upd.st = ST_HELD;
                    upd.rc = '0;
                end
            end
            F_FREE: upd.st = ST_UNUSED;
            F_MARK: upd.mark = 1'b1;
            default: upd = rdata;
        endcase
    end

    assign take = r_v2 && (r_e2.st == ST_RUNNABLE) &&
                  (!r_have || r_e2.lv < r_best.lv ||
                   (r_e2.lv == r_best.lv && r_e2.enq < r_best.enq));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_v1    = 1'b0;
        rd_addr = r_cnt[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_a1;
        wr_data = upd;
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt[IDX_W-1:0];
                wr_data = '0;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end
            end
            S_IDLE: begin
                rd_addr = is_walk ? '0 : IDX_W'(32'(i_slot));
                if (accept) begin
                    if (is_walk) begin
                        n_state = S_WALK;
                        n_v1    = 1'b1;
                        n_cnt   = CNT_W'(1);
                    end else if (i_func == F_CREATE || i_func == F_RUNNABLE ||
                                 i_func == F_SLEEP || i_func == F_FREE ||
                                 i_func == F_MARK) begin
                        n_state = S_SREAD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SREAD: begin
                wr_en   = r_ok;
                wr_addr = r_slot;
                n_state = S_DONE;
            end
            S_WALK: begin
                wr_en = r_v1;
                if (r_cnt < CNT_W'(SLOTS)) begin
                    n_v1  = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (!r_v1 && !r_v2) begin
                    n_state = is_sched ? S_LAST : S_DONE;
                end
            end
            S_LAST: begin
                wr_en         = r_have;
                wr_addr       = r_best_a;
                wr_data       = r_best;
                wr_data.enq   = r_time;
                wr_data.st    = ST_RUNNING;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_time      <= '0;
            r_slice     <= DEF_SLICE;
            r_aging     <= DEF_AGING;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_v1    <= n_v1;
            r_v2    <= r_v1 && (r_state == S_WALK) && is_sched;
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_IDX_W'(NUM_SLICE)) begin
                    r_slice[i_cfg_idx] <= i_cfg_data;
                end else if (i_cfg_idx == REG_AGING) begin
                    r_aging <= i_cfg_data;
                end
            end
            if (accept) begin
                r_have <= 1'b0;
                if (i_func == F_TICK) begin
                    r_time <= r_time + TIME_W'(1);
                end
            end else if (take) begin
                r_have <= 1'b1;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_a1 <= rd_addr;
        r_e2 <= upd;
        r_a2 <= r_a1;
        if (accept) begin
            r_func <= i_func;
            r_slot <= IDX_W'(32'(i_slot));
            r_ok   <= (32'(i_slot) < SLOTS);
            r_pf   <= 1'b0;
            r_ps   <= '0;
            r_pl   <= '0;
        end
        if (take) begin
            r_best   <= r_e2;
            r_best_a <= r_a2;
        end
        if (r_state == S_LAST && r_have) begin
            r_pf <= 1'b1;
            r_ps <= SLOT_W'(32'(r_best_a));
            r_pl <= r_best.lv;
        end
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_found <= r_pf;
            r_cslot <= r_ps;
            r_clvl  <= r_pl;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_chosen_slot  = r_cslot;
    assign o_chosen_level = r_clvl;
endmodule

>>> sv/mfs_checker.sv
// port-level checks for the feedback scheduler, bound to the top level
// depends on mfs_pkg and multilevel_feedback_scheduler
`timescale 1ns / 1ps
module mfs_checker #(
    parameter int LEVELS = mfs_pkg::DEF_LEVELS
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_found,
    input logic [mfs_pkg::SLOT_W-1:0]    o_chosen_slot,
    input logic [mfs_pkg::LVL_W-1:0]     o_chosen_level
);
    import mfs_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found) &&
        $stable(o_chosen_slot) && $stable(o_chosen_level))
        else $error("result changed while stalled");

    // empty result carries zeros
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_chosen_slot == '0 && o_chosen_level == '0)
        else $error("nonzero fields without a chosen slot");

    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_chosen_level) < LEVELS)
        else $error("chosen level out of range");

    // one item in flight at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after a transfer");

    // table clearing after reset
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("ready during table clear");
endmodule

bind multilevel_feedback_scheduler mfs_checker #(.LEVELS(LEVELS)) u_mfs_checker (.*);

>>> tb/testbench.sv
// self-checking testbench for multilevel_feedback_scheduler: random event streams
// against an in-bench scheduler predictor, with random idling on both channels
// depends on mfs_pkg and the scheduler rtl
`timescale 1ns / 1ps
module testbench;
    import mfs_pkg::*;

    localparam int NSLOT   = DEF_SLOTS;
    localparam int BOTTOM  = DEF_LEVELS - 1;
    localparam int N_RAND  = 1750;
    localparam int LIMIT   = 3000000;
    localparam logic [FUNC_W-1:0] F_NONE = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
    } t_event;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [LVL_W-1:0]  lvl;
    } t_pick;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [FUNC_W-1:0] i_func = '0;
    logic [SLOT_W-1:0] i_slot = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_found;
    logic [SLOT_W-1:0] o_chosen_slot;
    logic [LVL_W-1:0] o_chosen_level;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [REG_W-1:0] i_cfg_data = '0;

    multilevel_feedback_scheduler dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [REG_W-1:0]  slice_q [NUM_SLICE];
    logic [REG_W-1:0]  aging_q;
    logic [TIME_W-1:0] now_q;
    logic [1:0]        st_q   [NSLOT];
    logic [LVL_W-1:0]  lv_q   [NSLOT];
    logic [RC_W-1:0]   rc_q   [NSLOT];
    logic [TIME_W-1:0] enq_q  [NSLOT];
    logic [TIME_W-1:0] last_q [NSLOT];
    logic              mark_q [NSLOT];

    t_event pending_events[$];
    t_pick  expected_picks[$];
    int errors = 0;
    int cycle = 0;
    int hold_off = 0;

    task automatic requeue_slot(int s, int lv);
        lv_q[s] = LVL_W'(lv);
        enq_q[s] = now_q;
        rc_q[s] = '0;
    endtask

    function automatic logic [REG_W-1:0] slice_for(int lv);
        return slice_q[lv > 4 ? 4 : lv];
    endfunction

    task automatic predict_event(t_event ev, output t_pick r);
        int s;
        int best;
        bit have;
        s = ev.slot;
        best = 0;
        have = 0;
        r = '0;
        case (ev.func)
            F_TICK: begin
                now_q = now_q + 1;
                for (int i = 0; i < NSLOT; i++)
                    if (st_q[i] == ST_RUNNING) begin
                        if (rc_q[i] != 16'hFFFF) rc_q[i]++;
                        last_q[i] = now_q;
                    end
            end
            F_CREATE: if (st_q[s] == ST_UNUSED) begin
                st_q[s] = ST_HELD;
                requeue_slot(s, 0);
                last_q[s] = now_q;
                mark_q[s] = 1'b0;
            end
            F_RUNNABLE: if (st_q[s] == ST_HELD || st_q[s] == ST_RUNNING) st_q[s] = ST_RUNNABLE;
            F_SLEEP: if (st_q[s] != ST_UNUSED) begin
                st_q[s] = ST_HELD;
                rc_q[s] = '0;
            end
            F_FREE: st_q[s] = ST_UNUSED;
            F_MARK: mark_q[s] = 1'b1;
            F_SCHED: begin
                for (int i = 0; i < NSLOT; i++)
                    if (st_q[i] == ST_RUNNABLE && rc_q[i] >= slice_for(lv_q[i])
                            && lv_q[i] < BOTTOM)
                        requeue_slot(i, lv_q[i] + 1);
                for (int i = 0; i < NSLOT; i++) begin
                    if (st_q[i] != ST_RUNNABLE) continue;
                    if (TIME_W'(now_q - last_q[i]) > aging_q && lv_q[i] != 0)
                        requeue_slot(i, lv_q[i] - 1);
                    if (mark_q[i] && lv_q[i] < BOTTOM) begin
                        mark_q[i] = 1'b0;
                        requeue_slot(i, lv_q[i] + 1);
                    end
                end
                for (int i = 0; i < NSLOT; i++) begin
                    if (st_q[i] != ST_RUNNABLE) continue;
                    if (!have || lv_q[i] < lv_q[best] ||
                            (lv_q[i] == lv_q[best] && enq_q[i] < enq_q[best])) begin
                        best = i;
                        have = 1;
                    end
                end
                if (have) begin
                    enq_q[best] = now_q;
                    st_q[best] = ST_RUNNING;
                    r.found = 1'b1;
                    r.slot = SLOT_W'(best);
                    r.lvl = lv_q[best];
                end
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(int idx, logic [REG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_IDX_W'(idx);
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_AGING) aging_q = val;
        else slice_q[idx] = val;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || expected_picks.size() != 0) @(negedge i_clk);
        repeat (NSLOT + 20) @(negedge i_clk);
    endtask

    function automatic t_event mk(logic [FUNC_W-1:0] f, int s);
        t_event e;
        e.func = f;
        e.slot = SLOT_W'(s);
        return e;
    endfunction

    // pool of slots keeps the task table busy; rest is noise
    task automatic push_random(int n, int pool);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 30) pending_events.push_back(mk(F_TICK, 0));
            else if (r < 45) pending_events.push_back(mk(F_SCHED, 0));
            else if (r < 93)
                pending_events.push_back(mk(FUNC_W'($urandom_range(F_MARK, F_CREATE)),
                                            $urandom_range(pool - 1)));
            else pending_events.push_back(mk(FUNC_W'($urandom_range(7)),
                                             $urandom_range(63)));
        end
    endtask

    // driver
    int gap = 0;
    logic o_in_ready_q = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready_q) begin
                if (pending_events.size() != 0 && gap == 0) begin
                    {i_func, i_slot} <= pending_events[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid && pending_events.size() != 0) begin
                if (gap > 0) gap <= gap - 1;
                else begin
                    i_in_valid <= 1'b1;
                    {i_func, i_slot} <= pending_events[0];
                end
            end
        end
    end

    // transfer bookkeeping at the rising edge
    t_pick pred;
    always @(posedge i_clk) begin
        o_in_ready_q <= 1'b0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_event(pending_events.pop_front(), pred);
            expected_picks.push_back(pred);
            o_in_ready_q <= 1'b1;
            gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
        end
    end

    // monitor
    int stall = 0;
    int stall_left = 0;
    t_pick exp_pick;
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_picks.size() == 0) begin
                $display("%0t: unexpected result found=%0d slot=%0d level=%0d", $realtime,
                         o_found, o_chosen_slot, o_chosen_level);
                errors = errors + 1;
            end else begin
                exp_pick = expected_picks.pop_front();
                if (exp_pick.found !== o_found) begin
                    $display("%0t: found exp %0d got %0d", $realtime, exp_pick.found,
                             o_found);
                    errors = errors + 1;
                end
                if (exp_pick.slot !== o_chosen_slot) begin
                    $display("%0t: chosen_slot exp %0d got %0d", $realtime, exp_pick.slot,
                             o_chosen_slot);
                    errors = errors + 1;
                end
                if (exp_pick.lvl !== o_chosen_level) begin
                    $display("%0t: chosen_level exp %0d got %0d", $realtime, exp_pick.lvl,
                             o_chosen_level);
                    errors = errors + 1;
                end
            end
        end
        if (cycle >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (i_out_ready && o_out_valid) begin
            stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
            i_out_ready <= (stall == 0);
            stall_left <= stall;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        for (int i = 0; i < NUM_SLICE; i++) slice_q[i] = DEF_SLICE[i];
        aging_q = DEF_AGING;
        now_q = '0;
        for (int i = 0; i < NSLOT; i++) begin
            st_q[i] = ST_UNUSED;
            lv_q[i] = '0;
            rc_q[i] = '0;
            enq_q[i] = '0;
            last_q[i] = '0;
            mark_q[i] = 1'b0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every event, slot extremes, ignored cases, mark on an unused slot
        pending_events.push_back(mk(F_SCHED, 0));
        pending_events.push_back(mk(F_RUNNABLE, 63));
        pending_events.push_back(mk(F_SLEEP, 0));
        pending_events.push_back(mk(F_CREATE, 0));
        pending_events.push_back(mk(F_CREATE, 63));
        pending_events.push_back(mk(F_CREATE, 0));
        pending_events.push_back(mk(F_RUNNABLE, 0));
        pending_events.push_back(mk(F_RUNNABLE, 0));
        pending_events.push_back(mk(F_RUNNABLE, 63));
        pending_events.push_back(mk(F_MARK, 63));
        pending_events.push_back(mk(F_SCHED, 0));
        pending_events.push_back(mk(F_TICK, 0));
        pending_events.push_back(mk(F_TICK, 0));
        pending_events.push_back(mk(F_RUNNABLE, 0));
        pending_events.push_back(mk(F_SCHED, 0));
        pending_events.push_back(mk(F_SLEEP, 63));
        pending_events.push_back(mk(F_NONE, 42));
        pending_events.push_back(mk(F_FREE, 63));
        pending_events.push_back(mk(F_MARK, 21));
        pending_events.push_back(mk(F_SCHED, 0));
        wait_drained();

        // default registers, then extremes and a mix
        push_random(400, 8);
        wait_drained();
        for (int i = 0; i < NUM_SLICE; i++) write_reg(i, 16'd1);
        write_reg(REG_AGING, 16'd1);
        push_random(300, 64);
        wait_drained();
        for (int i = 0; i < NUM_SLICE; i++) write_reg(i, 16'hFFFF);
        write_reg(REG_AGING, 16'hFFFF);
        push_random(300, 16);
        wait_drained();

        // receiver holds off long while the sender keeps offering
        hold_off = 400;
        push_random(250, 12);
        wait_drained();
        for (int i = 0; i < NUM_SLICE; i++) write_reg(i, REG_W'($urandom_range(1, 6)));
        write_reg(REG_AGING, REG_W'($urandom_range(1, 30)));
        push_random(250, 10);
        wait_drained();
        push_random(250, 6);
        wait_drained();

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
